### hw/rtl/lse_ess_pkg.sv
// Shared types, constants and constant tables of the log-sum-exp / ESS block.
`timescale 1ns / 1ps
package lse_ess_pkg;

    localparam int FRAC_BITS = 16;
    localparam int EXP_SH0   = 30 - FRAC_BITS;

    localparam logic signed [23:0] LW_MIN = 24'sh800000;
    localparam logic signed [23:0] LW_MAX = 24'sh7FFFFF;

    // ln(2) in Q30.
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    // 26 * ln(2) in Q30: at or beyond this the exponential rounds to zero.
    localparam logic [37:0] EXP_ZERO_BOUND = 38'd19350789068;

    localparam logic [26:0] ESS_MAX = 27'd67108864;

    typedef struct packed {
        logic signed [23:0] max;
        logic               empty;
    } lse_job_t;

    // Truncated reciprocal 2^32 / d, used with a single correction step.
    function automatic logic [31:0] recip(input logic [3:0] d);
        logic [31:0] r;
        unique case (d)
            4'd2:    r = 32'd2147483648;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741824;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870912;
            4'd9:    r = 32'd477218588;
            4'd10:   r = 32'd429496729;
            4'd11:   r = 32'd390451572;
            4'd12:   r = 32'd357913941;
            4'd13:   r = 32'd330382099;
            default: r = 32'hFFFFFFFF;
        endcase
        return r;
    endfunction

    // ln(2) * 2^b in Q30 for the range reduction.
    function automatic logic [37:0] ln2_shl(input logic [2:0] b);
        return {8'b0, LN2_Q30} << b;
    endfunction

endpackage

### hw/rtl/lse_ess_if.sv
// Handshake interfaces for the weight input and the result output.
`timescale 1ns / 1ps
interface lse_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] log_weight;
    logic               last;
    logic               no_weight;

    modport source (output valid, output log_weight, output last, output no_weight,
                    input ready);
    modport sink (input valid, input log_weight, input last, input no_weight,
                  output ready);
endinterface

interface lse_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] log_sum_exp;
    logic [26:0]        ess;
    logic               empty_set;

    modport source (output valid, output log_sum_exp, output ess, output empty_set,
                    input ready);
    modport sink (input valid, input log_sum_exp, input ess, input empty_set,
                  output ready);
endinterface

### hw/rtl/log_sum_exp_effective_sample_size_core.sv
// Top level of the log-sum-exp and effective sample size block.
`timescale 1ns / 1ps
//
//  Channel   Dir   Word contents
//  --------  ----  ---------------------------------------------------------
//  samples   in    log_weight (Q8.16 signed), last, no_weight
//  results   out   log_sum_exp (Q8.16 signed), ess (Q11.16), empty_set
//
// Weights are taken one per cycle while the back end is idle and no set is
// queued. Closing a set of N weights runs two exponential passes over the
// store, one iterative exp per weight in each, then the normalisation, log
// series and the 60-step divider.
// Reset is asynchronous and active low; the weight store is not cleared, as
// only entries written in the current set are ever read.
// A result waits in its output register while the front end already accepts
// the next set; the back end stalls in its final state if that word is not taken.
module log_sum_exp_effective_sample_size_core
    import lse_ess_pkg::*;
#(
    parameter int MAX_WEIGHTS = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    lse_in_if.sink     samples,
    lse_out_if.source  results
);

    localparam int AW = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
    localparam int CW = $clog2(MAX_WEIGHTS + 1);

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [23:0] wr_data;
    logic               job_valid;
    logic               job_ready;
    lse_job_t           job;
    logic [CW-1:0]      job_count;
    logic               back_busy;

    // The front end stores weights and hands each closed set over as a job.
    lse_ess_front #(
        .MAX_WEIGHTS (MAX_WEIGHTS),
        .AW          (AW),
        .CW          (CW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .job_count (job_count),
        .back_busy (back_busy)
    );

    // The back end runs both passes over the store and produces the result word.
    lse_ess_back #(
        .MAX_WEIGHTS (MAX_WEIGHTS),
        .AW          (AW),
        .CW          (CW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .job_count (job_count),
        .busy      (back_busy),
        .results   (results)
    );

endmodule

### hw/rtl/lse_ess_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lse_ess_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [59:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [59:0] quo
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic [59:0] num_reg;
    logic        done_reg;

    logic [32:0] trial;
    logic        ge;
    logic [32:0] diff;

    always_comb
    begin
        trial = {rem_reg, num_reg[59]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd59;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            num_reg <= {num_reg[58:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

### hw/rtl/lse_ess_exp.sv
// Iterative fixed-point exp(-m): range reduction, then a nested Taylor series.
`timescale 1ns / 1ps
module lse_ess_exp
    import lse_ess_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [23:0] m,
    output logic        done,
    output logic [16:0] result
);

    typedef enum logic [2:0] {E_IDLE, E_RED, E_MUL, E_DIV, E_FIX, E_OUT} state_t;

    state_t      state_reg;
    logic [37:0] big_reg;
    logic [4:0]  k_reg;
    logic [2:0]  bit_reg;
    logic [30:0] p_reg;
    logic [3:0]  i_reg;
    logic [60:0] prod_reg;
    logic [62:0] t_reg;
    logic [16:0] res_reg;
    logic        done_reg;

    logic [37:0] big_start;
    logic [37:0] cand;
    logic [30:0] x_w;
    logic [30:0] q0_w;
    logic [34:0] qd_w;
    logic [34:0] rem_w;
    logic [30:0] q_w;
    logic [30:0] p_next;
    logic [5:0]  sh_w;
    logic [39:0] round_w;

    always_comb
    begin
        big_start = {m, 14'b0};
        cand      = ln2_shl(bit_reg);
        x_w       = prod_reg[60:30];
        q0_w      = t_reg[62:32];
        qd_w      = {4'b0, q0_w} * {31'b0, i_reg};
        rem_w     = {4'b0, x_w} - qd_w;
        q_w       = q0_w + {30'b0, (rem_w >= {31'b0, i_reg})};
        p_next    = 31'h40000000 - q_w;
        sh_w      = 6'(EXP_SH0) + {1'b0, k_reg};
        round_w   = ({9'b0, p_reg} + (40'd1 << (sh_w - 6'd1))) >> sh_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
            big_reg   <= '0;
            k_reg     <= '0;
            bit_reg   <= '0;
            p_reg     <= '0;
            i_reg     <= '0;
            prod_reg  <= '0;
            t_reg     <= '0;
            res_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                E_IDLE:
                begin
                    if (start)
                    begin
                        big_reg <= big_start;
                        k_reg   <= '0;
                        bit_reg <= 3'd4;
                        if (big_start >= EXP_ZERO_BOUND)
                        begin
                            res_reg  <= '0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= E_RED;
                        end
                    end
                end
                E_RED:
                begin
                    if (big_reg >= cand)
                    begin
                        big_reg <= big_reg - cand;
                        k_reg   <= k_reg | (5'd1 << bit_reg);
                    end
                    if (bit_reg == 3'd0)
                    begin
                        p_reg     <= 31'h40000000;
                        i_reg     <= 4'd10;
                        state_reg <= E_MUL;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 3'd1;
                    end
                end
                E_MUL:
                begin
                    prod_reg  <= 61'(big_reg[29:0]) * 61'(p_reg);
                    state_reg <= E_DIV;
                end
                E_DIV:
                begin
                    t_reg     <= 63'(x_w) * 63'(recip(i_reg));
                    state_reg <= E_FIX;
                end
                E_FIX:
                begin
                    p_reg <= p_next;
                    if (i_reg == 4'd1)
                    begin
                        state_reg <= E_OUT;
                    end
                    else
                    begin
                        i_reg     <= i_reg - 4'd1;
                        state_reg <= E_MUL;
                    end
                end
                E_OUT:
                begin
                    res_reg   <= round_w[16:0];
                    done_reg  <= 1'b1;
                    state_reg <= E_IDLE;
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

### hw/rtl/lse_ess_front.sv
// Front end: takes weights, writes the store, tracks count and maximum, queues jobs.
`timescale 1ns / 1ps
module lse_ess_front
    import lse_ess_pkg::*;
#(
    parameter int MAX_WEIGHTS = 1024,
    parameter int AW = 10,
    parameter int CW = 11
)
(
    input  logic               clk,
    input  logic               rst_n,
    lse_in_if.sink             samples,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic signed [23:0] wr_data,
    output logic               job_valid,
    input  logic               job_ready,
    output lse_job_t           job,
    output logic [CW-1:0]      job_count,
    input  logic               back_busy
);

    logic [CW-1:0]      count_reg;
    logic signed [23:0] max_reg;
    lse_job_t           q_job_reg [2];
    logic [CW-1:0]      q_cnt_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         fill_reg;

    logic               accept;
    logic               take;
    logic               push;
    logic               pop;
    logic [CW-1:0]      cnt_next;
    logic signed [23:0] max_next;

    always_comb
    begin
        samples.ready = (fill_reg == 2'd0) && !back_busy;
        accept        = samples.valid && samples.ready;
        take          = accept && !samples.no_weight && (count_reg < CW'(MAX_WEIGHTS));
        push          = accept && samples.last;
        pop           = job_valid && job_ready;
        cnt_next      = take ? count_reg + CW'(1) : count_reg;
        max_next      = (take && (samples.log_weight > max_reg)) ? samples.log_weight
                                                                 : max_reg;
    end

    assign wr_en     = take;
    assign wr_addr   = count_reg[AW-1:0];
    assign wr_data   = samples.log_weight;
    assign job_valid = fill_reg != 2'd0;
    assign job       = q_job_reg[rd_ptr_reg];
    assign job_count = q_cnt_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            max_reg    <= LW_MIN;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                count_reg  <= '0;
                max_reg    <= LW_MIN;
                wr_ptr_reg <= !wr_ptr_reg;
            end
            else
            begin
                count_reg <= cnt_next;
                max_reg   <= max_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_job_reg[wr_ptr_reg] <= '{max: max_next, empty: (cnt_next == '0)};
            q_cnt_reg[wr_ptr_reg] <= cnt_next;
        end
    end

endmodule

### hw/rtl/lse_ess_back.sv
// Back end: weight store, the two passes, the log, the ESS division and the result word.
`timescale 1ns / 1ps
module lse_ess_back
    import lse_ess_pkg::*;
#(
    parameter int MAX_WEIGHTS = 1024,
    parameter int AW = 10,
    parameter int CW = 11
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic signed [23:0] wr_data,
    input  logic               job_valid,
    output logic               job_ready,
    input  lse_job_t           job,
    input  logic [CW-1:0]      job_count,
    output logic               busy,
    lse_out_if.source          results
);

    typedef enum logic [4:0] {
        B_IDLE, B_E_RD, B_E_GO, B_E_WAIT, B_NORM, B_DIV_Z, B_Z2, B_SER_A, B_SER_B,
        B_LSE, B_S_RD, B_S_GO, B_S_WAIT, B_S_ACC, B_ESS, B_ESS_WAIT, B_FIN
    } state_t;

    logic signed [23:0] mem [MAX_WEIGHTS];
    logic signed [23:0] rd_data_reg;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg;
    logic signed [23:0] max_reg;
    logic [31:0]        sum_reg;
    logic [31:0]        norm_reg;
    logic [4:0]         b_reg;
    logic [29:0]        z2_reg;
    logic [29:0]        pw_reg;
    logic [3:0]         j_reg;
    logic [31:0]        acc_reg;
    logic [61:0]        t_reg;
    logic [59:0]        pp_reg;
    logic signed [23:0] lse_reg;
    logic [33:0]        sqp_reg;
    logic [26:0]        ess_reg;
    logic               empty_reg;
    logic               out_valid_reg;
    logic signed [23:0] out_lse_reg;
    logic [26:0]        out_ess_reg;
    logic               out_empty_reg;

    logic               exp_start;
    logic [23:0]        exp_m;
    logic               exp_done;
    logic [16:0]        exp_w;
    logic               div_start;
    logic [59:0]        div_num;
    logic [31:0]        div_den;
    logic               div_done;
    logic [59:0]        div_quo;

    logic signed [23:0] ref_w;
    logic [24:0]        diff_w;
    logic [17:0]        term_w;
    logic [32:0]        sat_sum;
    logic [31:0]        sum_next;
    logic [29:0]        x_w;
    logic [59:0]        zz_w;
    logic [29:0]        q0_w;
    logic [33:0]        qd_w;
    logic [33:0]        rem_w;
    logic [29:0]        q_w;
    logic [35:0]        v_w;
    logic [35:0]        ln_w;
    logic [25:0]        lse_wide;
    logic [32:0]        ess_q;
    logic               out_free;
    logic               last_idx;

    lse_ess_exp u_exp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (exp_start),
        .m      (exp_m),
        .done   (exp_done),
        .result (exp_w)
    );

    lse_ess_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[idx_reg[AW-1:0]];
    end

    always_comb
    begin
        ref_w     = (state_reg == B_S_GO) ? lse_reg : max_reg;
        diff_w    = {ref_w[23], ref_w} - {rd_data_reg[23], rd_data_reg};
        exp_m     = diff_w[23:0];
        exp_start = (state_reg == B_E_GO) || (state_reg == B_S_GO);

        term_w    = (state_reg == B_S_ACC) ? 18'((sqp_reg + 34'd32768) >> 16)
                                           : {1'b0, exp_w};
        sat_sum   = {1'b0, sum_reg} + {15'b0, term_w};
        sum_next  = sat_sum[32] ? 32'hFFFFFFFF : sat_sum[31:0];
        last_idx  = (idx_reg + CW'(1)) == count_reg;

        // Fraction of the normalised sum in Q30.
        x_w       = norm_reg[30:1];
        div_start = ((state_reg == B_NORM) && norm_reg[31])
                    || ((state_reg == B_ESS) && (sum_reg != '0));
        if (state_reg == B_ESS)
        begin
            div_num = {27'b0, 33'h100000000 + {2'b0, sum_reg[31:1]}};
            div_den = sum_reg;
        end
        else
        begin
            div_num = {x_w, 30'b0};
            div_den = {2'b10, x_w};
        end

        zz_w     = 60'(div_quo[29:0]) * 60'(div_quo[29:0]);
        q0_w     = t_reg[61:32];
        qd_w     = 34'(q0_w) * 34'(j_reg);
        rem_w    = 34'(pw_reg) - qd_w;
        q_w      = q0_w + 30'(rem_w >= 34'(j_reg));

        v_w      = 36'(b_reg[3:0]) * 36'(LN2_Q30) + {3'b0, acc_reg, 1'b0};
        ln_w     = (v_w + 36'd8192) >> 14;
        lse_wide = {{2{max_reg[23]}}, max_reg} + {5'b0, ln_w[20:0]};

        ess_q    = div_quo[32:0];
        out_free = !out_valid_reg || results.ready;
    end

    assign job_ready         = state_reg == B_IDLE;
    assign busy              = state_reg != B_IDLE;
    assign results.valid       = out_valid_reg;
    assign results.log_sum_exp = out_lse_reg;
    assign results.ess         = out_ess_reg;
    assign results.empty_set   = out_empty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            max_reg       <= LW_MIN;
            sum_reg       <= '0;
            norm_reg      <= '0;
            b_reg         <= '0;
            z2_reg        <= '0;
            pw_reg        <= '0;
            j_reg         <= '0;
            acc_reg       <= '0;
            t_reg         <= '0;
            pp_reg        <= '0;
            lse_reg       <= LW_MIN;
            sqp_reg       <= '0;
            ess_reg       <= '0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_lse_reg   <= LW_MIN;
            out_ess_reg   <= '0;
            out_empty_reg <= 1'b0;
        end
        else
        begin
            // In the final state the output register is reloaded instead.
            if (results.ready && (state_reg != B_FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (job_valid)
                    begin
                        count_reg <= job_count;
                        max_reg   <= job.max;
                        idx_reg   <= '0;
                        sum_reg   <= '0;
                        empty_reg <= job.empty;
                        if (job.empty)
                        begin
                            lse_reg   <= LW_MIN;
                            ess_reg   <= '0;
                            state_reg <= B_FIN;
                        end
                        else
                        begin
                            state_reg <= B_E_RD;
                        end
                    end
                end
                B_E_RD:
                begin
                    state_reg <= B_E_GO;
                end
                B_E_GO:
                begin
                    state_reg <= B_E_WAIT;
                end
                B_E_WAIT:
                begin
                    if (exp_done)
                    begin
                        sum_reg <= sum_next;
                        idx_reg <= idx_reg + CW'(1);
                        if (last_idx)
                        begin
                            norm_reg  <= sum_next;
                            b_reg     <= 5'd31;
                            state_reg <= B_NORM;
                        end
                        else
                        begin
                            state_reg <= B_E_RD;
                        end
                    end
                end
                B_NORM:
                begin
                    if (norm_reg[31])
                    begin
                        state_reg <= B_DIV_Z;
                    end
                    else
                    begin
                        norm_reg <= {norm_reg[30:0], 1'b0};
                        b_reg    <= b_reg - 5'd1;
                    end
                end
                B_DIV_Z:
                begin
                    if (div_done)
                    begin
                        pw_reg    <= div_quo[29:0];
                        state_reg <= B_Z2;
                    end
                end
                B_Z2:
                begin
                    z2_reg    <= zz_w[59:30];
                    j_reg     <= 4'd1;
                    acc_reg   <= '0;
                    state_reg <= B_SER_A;
                end
                B_SER_A:
                begin
                    t_reg     <= 62'(pw_reg) * 62'(recip(j_reg));
                    pp_reg    <= 60'(pw_reg) * 60'(z2_reg);
                    state_reg <= B_SER_B;
                end
                B_SER_B:
                begin
                    acc_reg <= acc_reg + 32'(q_w);
                    pw_reg  <= pp_reg[59:30];
                    if (j_reg == 4'd13)
                    begin
                        state_reg <= B_LSE;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 4'd2;
                        state_reg <= B_SER_A;
                    end
                end
                B_LSE:
                begin
                    if ($signed(lse_wide) > 26'sd8388607)
                    begin
                        lse_reg <= LW_MAX;
                    end
                    else
                    begin
                        lse_reg <= lse_wide[23:0];
                    end
                    idx_reg   <= '0;
                    sum_reg   <= '0;
                    state_reg <= B_S_RD;
                end
                B_S_RD:
                begin
                    state_reg <= B_S_GO;
                end
                B_S_GO:
                begin
                    state_reg <= B_S_WAIT;
                end
                B_S_WAIT:
                begin
                    if (exp_done)
                    begin
                        sqp_reg   <= 34'(exp_w) * 34'(exp_w);
                        state_reg <= B_S_ACC;
                    end
                end
                B_S_ACC:
                begin
                    sum_reg <= sum_next;
                    idx_reg <= idx_reg + CW'(1);
                    if (last_idx)
                    begin
                        state_reg <= B_ESS;
                    end
                    else
                    begin
                        state_reg <= B_S_RD;
                    end
                end
                B_ESS:
                begin
                    if (sum_reg == '0)
                    begin
                        ess_reg   <= '0;
                        state_reg <= B_FIN;
                    end
                    else
                    begin
                        state_reg <= B_ESS_WAIT;
                    end
                end
                B_ESS_WAIT:
                begin
                    if (div_done)
                    begin
                        ess_reg   <= (ess_q > 33'(ESS_MAX)) ? ESS_MAX : ess_q[26:0];
                        state_reg <= B_FIN;
                    end
                end
                B_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_lse_reg   <= lse_reg;
                        out_ess_reg   <= ess_reg;
                        out_empty_reg <= empty_reg;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    a_nonempty_job: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_IDLE && state_reg != B_FIN) |-> (count_reg != '0))
        else $error("pass running on an empty weight set");

    a_index_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_E_GO || state_reg == B_S_GO) |-> (idx_reg < count_reg))
        else $error("store read beyond the weights of the set");

    a_lse_not_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_S_GO) |-> (lse_reg >= max_reg))
        else $error("log-sum-exp below the running maximum");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == B_FIN))
        else $error("result word raised outside the final state");

endmodule

### tb/log_sum_exp_effective_sample_size_core_tb.sv
// Self-checking testbench of the log-sum-exp and effective sample size core.
`timescale 1ns / 1ps
module log_sum_exp_effective_sample_size_core_tb;
    import lse_ess_pkg::*;

    // Sets of up to this many weights are kept; a larger set is truncated.
    localparam int MAX_W = 1024;
    // Cycles without any accepted word before the run is abandoned. The one
    // full-capacity set runs one iterative exp per weight in both passes.
    localparam int STALL_LIMIT = 400000;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] SAT_32  = 64'hFFFF_FFFF;

    typedef struct packed {
        logic signed [23:0] lse;
        logic [26:0]        ess;
        logic               empty;
    } set_result_t;

    logic clk;
    logic rst_n;

    lse_in_if  samples();
    lse_out_if results();

    log_sum_exp_effective_sample_size_core #(.MAX_WEIGHTS(MAX_W)) i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples.sink),
        .results (results.source)
    );

    // Shadow copy of the block's set state.
    logic signed [23:0] weight_mem [MAX_W];
    int                 weight_cnt;
    logic signed [23:0] set_max;
    set_result_t        pending_results[$];

    int error_count;
    int send_idle_pct;
    int recv_idle_pct;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Fixed-point exp(-m): range reduction by ln 2, then a nested Taylor
    // series on the remainder in Q30, finally a rounding shift back to Q.F.
    function automatic logic [63:0] exp_neg_fx(input logic [63:0] m);
        logic [63:0] scaled;
        logic [63:0] k;
        logic [63:0] r;
        logic [63:0] p;
        logic [63:0] sh;
        scaled = m << (30 - FRAC_BITS);
        k = scaled / 64'(LN2_Q30);
        r = scaled - k * 64'(LN2_Q30);
        p = Q30_ONE;
        for (int i = 10; i >= 1; i--)
        begin
            p = Q30_ONE - ((r * p) >> 30) / 64'(i);
        end
        sh = 64'(30 - FRAC_BITS) + k;
        if (sh >= 64'd40)
            return 64'd0;
        return (p + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // Natural log of s / 2^F for s >= 2^F, by the atanh series on the mantissa.
    function automatic logic [63:0] log_fx(input logic [31:0] s);
        int          b;
        logic [63:0] frac;
        logic [63:0] x;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] pw;
        logic [63:0] acc;
        logic [63:0] v;
        b = 31;
        while (b > 0 && !s[b])
            b--;
        frac = 64'(s) - (64'd1 << b);
        if (b >= 30)
            x = frac >> (b - 30);
        else
            x = frac << (30 - b);
        z   = (x << 30) / ((64'd1 << 31) + x);
        z2  = (z * z) >> 30;
        pw  = z;
        acc = 64'd0;
        for (int j = 1; j <= 13; j += 2)
        begin
            acc = acc + pw / 64'(j);
            pw  = (pw * z2) >> 30;
        end
        v = 64'(b >= FRAC_BITS ? b - FRAC_BITS : 0) * 64'(LN2_Q30) + 2 * acc;
        return (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    endfunction

    function automatic void clear_set_state();
        weight_cnt = 0;
        set_max    = LW_MIN;
    endfunction

    // Updates the shadow state with one accepted word and, on a closing word,
    // queues the log-sum-exp and ESS that the block must produce.
    function automatic void predict_lse_ess(input logic signed [23:0] lw,
                                            input logic last, input logic nw);
        logic [63:0]     acc;
        logic [63:0]     w;
        logic [63:0]     sq_sum;
        logic [63:0]     e;
        longint          lse;
        set_result_t     res;
        if (!nw && weight_cnt < MAX_W)
        begin
            weight_mem[weight_cnt] = lw;
            weight_cnt++;
            if (lw > set_max)
                set_max = lw;
        end
        if (!last)
            return;
        if (weight_cnt == 0)
        begin
            res.lse   = LW_MIN;
            res.ess   = '0;
            res.empty = 1'b1;
            pending_results.push_back(res);
            clear_set_state();
            return;
        end
        acc = 64'd0;
        for (int i = 0; i < weight_cnt; i++)
        begin
            acc = acc + exp_neg_fx(64'(longint'(set_max) - longint'(weight_mem[i])));
            if (acc > SAT_32)
                acc = SAT_32;
        end
        lse = longint'(set_max) + longint'(log_fx(acc[31:0]));
        if (lse > longint'(LW_MAX))
            lse = longint'(LW_MAX);
        sq_sum = 64'd0;
        for (int i = 0; i < weight_cnt; i++)
        begin
            w = exp_neg_fx(64'(lse - longint'(weight_mem[i])));
            sq_sum = sq_sum + ((w * w + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
            if (sq_sum > SAT_32)
                sq_sum = SAT_32;
        end
        res.lse   = lse[23:0];
        res.empty = 1'b0;
        if (sq_sum == 64'd0)
        begin
            res.ess = '0;
        end
        else
        begin
            e = ((64'd1 << (2 * FRAC_BITS)) + sq_sum / 2) / sq_sum;
            res.ess = (e > 64'(ESS_MAX)) ? ESS_MAX : e[26:0];
        end
        pending_results.push_back(res);
        clear_set_state();
    endfunction

    // Sends one word, with a random gap in front of it. Valid is only lowered
    // during a gap, so back-to-back words keep it high without a glitch.
    task automatic send_word(input logic signed [23:0] lw, input logic last,
                             input logic nw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid      <= 1'b1;
        samples.log_weight <= lw;
        samples.last       <= last;
        samples.no_weight  <= nw;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        predict_lse_ess(lw, last, nw);
    endtask

    // Sends a whole set of n weights, the last one closing it.
    task automatic send_set(input logic signed [23:0] lw_set[$]);
        for (int i = 0; i < lw_set.size(); i++)
            send_word(lw_set[i], i == lw_set.size() - 1, 1'b0);
    endtask

    // Extremes of the weight range, alone and mixed, and a spread set.
    task automatic test_extremes();
        send_set('{LW_MAX});
        send_set('{LW_MIN});
        send_set('{LW_MIN, LW_MAX});
        send_set('{LW_MAX, LW_MAX, LW_MAX});
        send_set('{24'sd0, 24'sd0});
        send_set('{24'sd65536, -24'sd65536, 24'sd0, 24'sd32768});
        send_set('{24'sh555555, -24'sh2AAAAA, 24'sh7FFFFE, 24'sh000001});
    endtask

    // Empty sets, weightless words inside a set, and a weightless close.
    task automatic test_weightless();
        send_word(24'sh123456, 1'b1, 1'b1);
        send_word(LW_MAX, 1'b0, 1'b1);
        send_word(LW_MIN, 1'b1, 1'b1);
        send_word(24'sd1000, 1'b0, 1'b0);
        send_word(LW_MAX, 1'b0, 1'b1);
        send_word(24'sd3000, 1'b0, 1'b0);
        send_word(LW_MIN, 1'b1, 1'b1);
    endtask

    // A full set plus extra words that must be dropped. All weights equal at
    // the top of the range: lse saturates and every normalised weight is one,
    // so the ESS equals the reciprocal of the number of stored weights.
    task automatic test_capacity();
        for (int i = 0; i < MAX_W + 6; i++)
            send_word(i < MAX_W ? LW_MAX : 24'sh000100, i == MAX_W + 5, 1'b0);
    endtask

    function automatic logic signed [23:0] random_weight(input int base);
        int v;
        if ($urandom_range(3) == 0)
            return 24'($urandom);
        v = base + int'($urandom_range(1 << 20)) - (1 << 19);
        if (v > int'(LW_MAX))
            v = int'(LW_MAX);
        if (v < int'(LW_MIN))
            v = int'(LW_MIN);
        return 24'(v);
    endfunction

    // Random sets, mostly small and clustered so that the exponentials matter,
    // with stray weightless words and the odd empty or weightless close.
    task automatic test_random_sets(input int n_words);
        int sent;
        int n;
        int base;
        sent = 0;
        while (sent < n_words)
        begin
            n    = ($urandom_range(19) == 0) ? $urandom_range(40, 64)
                                             : $urandom_range(1, 12);
            base = int'(24'sh0 + 24'($urandom));
            base = (base << 8) >>> 8;
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_word(24'($urandom), 1'b0, 1'b1);
                send_word(random_weight(base), i == n - 1, 1'b0);
                sent++;
            end
            if ($urandom_range(14) == 0)
            begin
                send_word(24'($urandom), 1'b1, 1'b1);
                sent++;
            end
        end
    endtask

    // Receiver: checks each taken word against the oldest expectation and
    // draws a fresh random stall for the next cycle.
    always @(posedge clk)
    begin
        set_result_t exp_res;
        if (rst_n && results.valid && results.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word lse=%0d ess=%0d empty=%0b",
                         $time, results.log_sum_exp, results.ess, results.empty_set);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (results.log_sum_exp !== exp_res.lse)
                begin
                    $display("%0t: log_sum_exp expected %0d actual %0d",
                             $time, exp_res.lse, results.log_sum_exp);
                    error_count++;
                end
                if (results.ess !== exp_res.ess)
                begin
                    $display("%0t: ess expected %0d actual %0d",
                             $time, exp_res.ess, results.ess);
                    error_count++;
                end
                if (results.empty_set !== exp_res.empty)
                begin
                    $display("%0t: empty_set expected %0b actual %0b",
                             $time, exp_res.empty, results.empty_set);
                    error_count++;
                end
            end
        end
        results.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((samples.valid && samples.ready) || (results.valid && results.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        send_idle_pct = 26;
        recv_idle_pct = 83;
        clear_set_state();
        rst_n              <= 1'b0;
        samples.valid      <= 1'b0;
        samples.log_weight <= '0;
        samples.last       <= 1'b0;
        samples.no_weight  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_weightless();
        test_random_sets(180);
        send_idle_pct = 83;
        recv_idle_pct = 26;
        test_capacity();
        test_random_sets(180);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sets(180);

        samples.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
